FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

FILE: hw/rtl/cura_pkg.sv
// package with constants and codes of the chunked upload reassembler
package cura_pkg;

  localparam int unsigned MaxChunksDef  = 64;
  localparam int unsigned MaxPayloadDef = 256;
  localparam logic [15:0] TimeoutReset  = 16'd5000;

  typedef enum logic [1:0] {
    CMD_CHUNK = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_BYTE_OK    = 4'd0,
    ST_STORED     = 4'd1,
    ST_COMPLETE   = 4'd2,
    ST_NO_UPLOAD  = 4'd3,
    ST_ZERO_TOTAL = 4'd4,
    ST_RANGE      = 4'd5,
    ST_DUPLICATE  = 4'd6,
    ST_OVERCAP    = 4'd7,
    ST_TICK_OK    = 4'd8,
    ST_TIMEOUT    = 4'd9,
    ST_DISCONNECT = 4'd10,
    ST_READ_EMPTY = 4'd11
  } status_e;

  typedef enum logic [2:0] {
    MODE_WAIT  = 3'b001,
    MODE_STORE = 3'b010,
    MODE_DROP  = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_LEN  = 3'b010,
    FSM_BYTE = 3'b100
  } fsm_e;

endpackage

FILE: hw/rtl/cura_ram.sv
// simple dual port ram, one write and one registered read port
module cura_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/chunked_upload_reassembler_unit.sv
// top level of the chunked upload reassembler
//
// channel   | handshake        | payload
// ----------+------------------+--------------------------------------------
// command   | start / busy     | cmd_i, chunk_index_i .. connected_i
// result    | done_o strobe    | status_o, restarted_o, data_out_o .. active
// config    | cfg_we_i         | cfg_wdata_i (timeout in ms)
//
// chunk, tick and unused commands: result the cycle after the transfer, busy stays low
// read: a length ram lookup, one more per empty slot passed, then the byte ram read,
//   then length lookups up to the next slot with data or the end to set data_last_o;
//   busy stays high until the result shows; single read port of each ram
// reset is asynchronous; no clearing pass, the slot rams are only read once written
// the receiver cannot stall: each result shows for one cycle only
`include "assert_macros.svh"

module chunked_upload_reassembler_unit #(
  parameter int unsigned MAX_CHUNKS  = cura_pkg::MaxChunksDef,
  parameter int unsigned MAX_PAYLOAD = cura_pkg::MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] chunk_index_i,
  input  logic [15:0] total_chunks_i,
  input  logic        has_data_i,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_end_i,
  input  logic [31:0] now_ms_i,
  input  logic        connected_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output logic [3:0]  status_o,
  output logic        restarted_o,
  output logic [7:0]  data_out_o,
  output logic        data_valid_o,
  output logic        data_last_o,
  output logic        upload_active_o
);

  localparam int unsigned CiW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned PosW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned Bytes = MAX_CHUNKS * MAX_PAYLOAD;
  localparam int unsigned Aw    = (Bytes > 1) ? $clog2(Bytes) : 1;

  // control state
  cura_pkg::fsm_e      fsm_q, fsm_d;
  cura_pkg::mode_e     mode_q, mode_d;
  logic [MAX_CHUNKS-1:0] map_q, map_d;
  logic [CntW-1:0]     exp_q, exp_d, cnt_q, cnt_d, rc_q, rc_d;
  logic                active_q, active_d, stamp_v_q, stamp_v_d, ready_q, ready_d;
  logic [31:0]         stamp_q, stamp_d;
  logic [PosW-1:0]     pos_q, pos_d, rp_q, rp_d;
  logic [CiW-1:0]      slot_q, slot_d;
  cura_pkg::status_e   rej_q, rej_d;
  logic [15:0]         tmo_q;
  logic                skip2_q, skip2_d;
  logic [7:0]          dout_q, dout_d;

  // result registers
  logic                done_q, done_d, rs_restart_q, rs_restart_d;
  logic                rs_valid_q, rs_valid_d, rs_last_q, rs_last_d, rs_active_q, rs_active_d;
  cura_pkg::status_e   rs_status_q, rs_status_d;
  logic [7:0]          rs_dout_q, rs_dout_d;

  // ram ports
  logic            bw_en, br_en, lw_en, lr_en;
  logic [Aw-1:0]   bw_addr, br_addr;
  logic [CiW-1:0]  lw_addr, lr_addr;
  logic [PosW-1:0] lw_data, lr_data;
  logic [7:0]      br_data;

  cura_ram #(.Depth(Bytes), .Width(8)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (bw_en),
    .waddr_i (bw_addr),
    .wdata_i (data_byte_i),
    .re_i    (br_en),
    .raddr_i (br_addr),
    .rdata_o (br_data)
  );

  cura_ram #(.Depth(MAX_CHUNKS), .Width(PosW)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (lw_addr),
    .wdata_i (lw_data),
    .re_i    (lr_en),
    .raddr_i (lr_addr),
    .rdata_o (lr_data)
  );

  assign busy = (fsm_q != cura_pkg::FSM_IDLE);

  always_comb begin
    logic            take;
    cura_pkg::status_e code;
    logic            fin;
    logic [CntW-1:0] rc_f;
    logic [31:0]     elapsed;
    fsm_d      = fsm_q;
    mode_d     = mode_q;
    map_d      = map_q;
    exp_d      = exp_q;
    cnt_d      = cnt_q;
    rc_d       = rc_q;
    rp_d       = rp_q;
    active_d   = active_q;
    stamp_v_d  = stamp_v_q;
    stamp_d    = stamp_q;
    ready_d    = ready_q;
    pos_d      = pos_q;
    slot_d     = slot_q;
    rej_d      = rej_q;
    skip2_d    = skip2_q;
    dout_d     = dout_q;
    done_d       = 1'b0;
    rs_status_d  = rs_status_q;
    rs_restart_d = 1'b0;
    rs_dout_d    = 8'd0;
    rs_valid_d   = 1'b0;
    rs_last_d    = 1'b0;
    rs_active_d  = rs_active_q;
    bw_en   = 1'b0;
    bw_addr = '0;
    br_en   = 1'b0;
    br_addr = Aw'(Aw'(rc_q[CiW-1:0]) * Aw'(MAX_PAYLOAD) + Aw'(rp_q));
    lw_en   = 1'b0;
    lw_addr = slot_q;
    lw_data = pos_q;
    lr_en   = 1'b0;
    lr_addr = rc_q[CiW-1:0];
    take    = start && !busy;
    code    = cura_pkg::ST_BYTE_OK;
    fin     = 1'b0;
    rc_f    = rc_q;
    elapsed = now_ms_i - stamp_q;

    case (fsm_q)
      cura_pkg::FSM_IDLE: begin
        if (take) begin
          case (cura_pkg::cmd_e'(cmd_i))
            cura_pkg::CMD_CHUNK: begin
              done_d = 1'b1;
              rs_status_d = cura_pkg::ST_BYTE_OK;
              if (mode_q == cura_pkg::MODE_WAIT) begin
                if (chunk_index_i == 16'd0) begin
                  map_d    = '0;
                  exp_d    = '0;
                  cnt_d    = '0;
                  ready_d  = 1'b0;
                  rc_d     = '0;
                  rp_d     = '0;
                  active_d = 1'b1;
                end else if (!active_q) begin
                  code = cura_pkg::ST_NO_UPLOAD;
                end
                if (code == cura_pkg::ST_BYTE_OK) begin
                  stamp_d   = now_ms_i;
                  stamp_v_d = 1'b1;
                  if (total_chunks_i == 16'd0) begin
                    code = cura_pkg::ST_ZERO_TOTAL;
                  end else if (total_chunks_i > 16'(MAX_CHUNKS)) begin
                    code = cura_pkg::ST_OVERCAP;
                  end else begin
                    if (16'(exp_d) != total_chunks_i) begin
                      // announced total changed: start over
                      if (exp_d != '0) begin
                        rs_restart_d = 1'b1;
                      end
                      map_d = '0;
                      cnt_d = '0;
                      exp_d = CntW'(total_chunks_i);
                    end
                    if (chunk_index_i >= 16'(exp_d)) begin
                      code = cura_pkg::ST_RANGE;
                    end else if (map_d[chunk_index_i[CiW-1:0]]) begin
                      code = cura_pkg::ST_DUPLICATE;
                    end
                  end
                end
                if (code != cura_pkg::ST_BYTE_OK) begin
                  rs_status_d = code;
                  rej_d  = code;
                  mode_d = chunk_end_i ? cura_pkg::MODE_WAIT : cura_pkg::MODE_DROP;
                end else begin
                  mode_d = cura_pkg::MODE_STORE;
                  slot_d = chunk_index_i[CiW-1:0];
                  pos_d  = '0;
                end
              end else if (mode_q == cura_pkg::MODE_DROP) begin
                rs_status_d = rej_q;
                if (chunk_end_i) begin
                  mode_d = cura_pkg::MODE_WAIT;
                end
              end
              if (mode_d == cura_pkg::MODE_STORE) begin
                rs_status_d = cura_pkg::ST_BYTE_OK;
                if (has_data_i) begin
                  if (pos_d < PosW'(MAX_PAYLOAD)) begin
                    bw_en   = 1'b1;
                    bw_addr = Aw'(Aw'(slot_d) * Aw'(MAX_PAYLOAD) + Aw'(pos_d));
                    pos_d   = pos_d + 1'b1;
                  end else begin
                    rs_status_d = cura_pkg::ST_OVERCAP;
                  end
                end
                if (chunk_end_i) begin
                  lw_en   = 1'b1;
                  lw_addr = slot_d;
                  lw_data = pos_d;
                  map_d[slot_d] = 1'b1;
                  cnt_d  = cnt_d + 1'b1;
                  mode_d = cura_pkg::MODE_WAIT;
                  pos_d  = '0;
                  rs_status_d = cura_pkg::ST_STORED;
                  if (cnt_d == exp_d) begin
                    rs_status_d = cura_pkg::ST_COMPLETE;
                    ready_d   = 1'b1;
                    rc_d      = '0;
                    rp_d      = '0;
                    active_d  = 1'b0;
                    stamp_v_d = 1'b0;
                    stamp_d   = '0;
                  end
                end
              end
              rs_active_d = active_d;
            end
            cura_pkg::CMD_TICK: begin
              done_d = 1'b1;
              rs_status_d = cura_pkg::ST_TICK_OK;
              if (active_q && (!connected_i || (stamp_v_q && elapsed > {16'd0, tmo_q}))) begin
                rs_status_d = connected_i ? cura_pkg::ST_TIMEOUT : cura_pkg::ST_DISCONNECT;
                map_d     = '0;
                exp_d     = '0;
                cnt_d     = '0;
                active_d  = 1'b0;
                stamp_v_d = 1'b0;
                stamp_d   = '0;
                if (mode_q == cura_pkg::MODE_STORE) begin
                  mode_d = cura_pkg::MODE_DROP;
                  rej_d  = cura_pkg::ST_NO_UPLOAD;
                end
              end
              rs_active_d = active_d;
            end
            cura_pkg::CMD_READ: begin
              if (ready_q && (rc_q < exp_q)) begin
                lr_en   = 1'b1;
                skip2_d = 1'b0;
                fsm_d   = cura_pkg::FSM_LEN;
              end else begin
                done_d      = 1'b1;
                rs_status_d = cura_pkg::ST_READ_EMPTY;
                rs_active_d = active_q;
              end
            end
            default: begin
              done_d      = 1'b1;
              rs_status_d = cura_pkg::ST_READ_EMPTY;
              rs_active_d = active_q;
            end
          endcase
        end
      end
      cura_pkg::FSM_LEN: begin
        if (rp_q >= lr_data) begin
          // slot used up, move to the next one
          rc_d = rc_q + 1'b1;
          rp_d = '0;
          if (rc_d < exp_q) begin
            lr_en   = 1'b1;
            lr_addr = rc_d[CiW-1:0];
          end else begin
            fin  = 1'b1;
            rc_f = rc_d;
          end
        end else begin
          fin = 1'b1;
        end
        if (fin) begin
          if (!skip2_q && (rc_f < exp_q)) begin
            br_en = 1'b1;
            fsm_d = cura_pkg::FSM_BYTE;
          end else begin
            fsm_d       = cura_pkg::FSM_IDLE;
            done_d      = 1'b1;
            rs_active_d = active_q;
            if (skip2_q) begin
              rs_status_d = cura_pkg::ST_BYTE_OK;
              rs_dout_d   = dout_q;
              rs_valid_d  = 1'b1;
              rs_last_d   = (rc_f >= exp_q);
            end else begin
              rs_status_d = cura_pkg::ST_READ_EMPTY;
            end
          end
        end
      end
      cura_pkg::FSM_BYTE: begin
        dout_d  = br_data;
        rp_d    = rp_q + 1'b1;
        skip2_d = 1'b1;
        lr_en   = 1'b1;
        fsm_d   = cura_pkg::FSM_LEN;
      end
      default: begin
        fsm_d = cura_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= cura_pkg::FSM_IDLE;
      mode_q      <= cura_pkg::MODE_WAIT;
      map_q       <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      rc_q        <= '0;
      rp_q        <= '0;
      active_q    <= 1'b0;
      stamp_v_q   <= 1'b0;
      stamp_q     <= '0;
      ready_q     <= 1'b0;
      pos_q       <= '0;
      slot_q      <= '0;
      rej_q       <= cura_pkg::ST_BYTE_OK;
      tmo_q       <= cura_pkg::TimeoutReset;
      skip2_q     <= 1'b0;
      done_q      <= 1'b0;
      rs_active_q <= 1'b0;
      rs_status_q <= cura_pkg::ST_BYTE_OK;
    end else begin
      fsm_q       <= fsm_d;
      mode_q      <= mode_d;
      map_q       <= map_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      rc_q        <= rc_d;
      rp_q        <= rp_d;
      active_q    <= active_d;
      stamp_v_q   <= stamp_v_d;
      stamp_q     <= stamp_d;
      ready_q     <= ready_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
      rej_q       <= rej_d;
      skip2_q     <= skip2_d;
      done_q      <= done_d;
      rs_active_q <= rs_active_d;
      rs_status_q <= rs_status_d;
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dout_q       <= dout_d;
    rs_dout_q    <= rs_dout_d;
    rs_valid_q   <= rs_valid_d;
    rs_last_q    <= rs_last_d;
    rs_restart_q <= rs_restart_d;
  end

  assign done_o          = done_q;
  assign status_o        = rs_status_q;
  assign restarted_o     = rs_restart_q;
  assign data_out_o      = rs_dout_q;
  assign data_valid_o    = rs_valid_q;
  assign data_last_o     = rs_last_q;
  assign upload_active_o = rs_active_q;

  `ASSERT_NEVER(a_active_and_ready, clk_i, rst_ni, active_q && ready_q, "active upload with ready content")
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, cnt_q <= exp_q, "received count above total")
  `ASSERT_CLK(a_transfer_answered, clk_i, rst_ni, (start && !busy) |=> (done_q || busy), "accepted transfer left without result or work")

endmodule
